/* rtl/core/cau_pkg.sv */
`timescale 1ns / 1ps
package cau_pkg;

    localparam int CAU_DW  = 16;                    // data width, Q4.12
    localparam int CAU_FB  = 12;                    // fraction bits
    localparam int CAU_PW  = 2 * CAU_DW;            // product width
    localparam int CAU_SW  = CAU_PW + 2;            // sum width with rounding headroom
    localparam int CAU_RW  = CAU_PW + 1;            // divider remainder / magnitude width
    localparam int CAU_QB  = CAU_DW + 1;            // quotient bits, one round bit below LSB
    localparam int CAU_DVW = CAU_RW + CAU_FB + 1;   // scaled dividend width
    localparam int CAU_CW  = CAU_PW + CAU_QB + 1;   // range check compare width

    localparam logic signed [CAU_SW-1:0] CAU_MAXV = CAU_SW'((1 << (CAU_DW - 1)) - 1);
    localparam logic signed [CAU_SW-1:0] CAU_MINV = -CAU_MAXV - CAU_SW'(1);
    localparam logic signed [CAU_SW-1:0] CAU_HALF = CAU_SW'(1 << (CAU_FB - 1));

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                      req_type;
        logic signed [CAU_DW-1:0] a_real;
        logic signed [CAU_DW-1:0] a_imag;
        logic signed [CAU_DW-1:0] b_real;
        logic signed [CAU_DW-1:0] b_imag;
    } t_req;

    typedef struct packed {
        logic signed [CAU_DW-1:0] res_real;
        logic signed [CAU_DW-1:0] res_imag;
        logic                     overflow;
        logic                     div_by_zero;
    } t_res;

    // one divider lane: partial remainder plus a shift register that feeds
    // dividend bits out at the top and takes quotient bits in at the bottom
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [CAU_RW-1:0] rem;
        logic [CAU_QB-1:0] bits;
    } t_lane;

    typedef struct packed {
        t_op                      op;
        logic signed [CAU_SW-1:0] sum_re;
        logic signed [CAU_SW-1:0] sum_im;
        logic [CAU_PW-1:0]        den;
        logic                     dz;
        t_lane                    lane_re;
        t_lane                    lane_im;
    } t_stage;

endpackage

/* rtl/core/cau_front.sv */
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_req   i_req,
    output logic   o_stall,
    output logic   o_valid,
    output t_stage o_stage,
    input  logic   i_stall
);

    logic   r1_v, r2_v, r3_v, r4_v;
    logic   s1, s2, s3, s4;
    t_req   r1_req;

    t_op                      r2_op;
    logic signed [CAU_PW-1:0] r2_rr, r2_ii, r2_ri, r2_ir;
    logic [CAU_PW-1:0]        r2_bb, r2_cc;
    logic signed [CAU_DW:0]   r2_as_re, r2_as_im;

    t_op                      r3_op;
    logic signed [CAU_SW-1:0] r3_sum_re, r3_sum_im;
    logic [CAU_PW-1:0]        r3_den;

    t_stage r4_stage;

    logic signed [CAU_PW-1:0] n2_rr, n2_ii, n2_ri, n2_ir, n2_bb, n2_cc;
    logic signed [CAU_DW:0]   n2_as_re, n2_as_im;
    logic signed [CAU_SW-1:0] n3_sum_re, n3_sum_im;
    t_stage                   n4_stage;

    function automatic t_lane prep_lane(input logic signed [CAU_SW-1:0] s,
                                        input logic [CAU_PW-1:0] den);
        t_lane              l;
        logic [CAU_RW-1:0]  mag;
        logic [CAU_DVW-1:0] dvd;
        l.neg  = s[CAU_SW-1];
        mag    = l.neg ? CAU_RW'(-s) : CAU_RW'(s);
        dvd    = CAU_DVW'(mag) << (CAU_FB + 1);
        l.ovf  = CAU_CW'(dvd) >= (CAU_CW'(den) << CAU_QB);
        l.rem  = CAU_RW'(dvd >> CAU_QB);
        l.bits = dvd[CAU_QB-1:0];
        return l;
    endfunction

    assign s4      = r4_v && i_stall;
    assign s3      = r3_v && s4;
    assign s2      = r2_v && s3;
    assign s1      = r1_v && s2;
    assign o_stall = s1;
    assign o_valid = r4_v;
    assign o_stage = r4_stage;

    always_comb begin
        n2_rr    = r1_req.a_real * r1_req.b_real;
        n2_ii    = r1_req.a_imag * r1_req.b_imag;
        n2_ri    = r1_req.a_real * r1_req.b_imag;
        n2_ir    = r1_req.a_imag * r1_req.b_real;
        n2_bb    = r1_req.b_real * r1_req.b_real;
        n2_cc    = r1_req.b_imag * r1_req.b_imag;
        n2_as_re = (r1_req.req_type == OP_SUB)
                 ? (CAU_DW+1)'(r1_req.a_real) - (CAU_DW+1)'(r1_req.b_real)
                 : (CAU_DW+1)'(r1_req.a_real) + (CAU_DW+1)'(r1_req.b_real);
        n2_as_im = (r1_req.req_type == OP_SUB)
                 ? (CAU_DW+1)'(r1_req.a_imag) - (CAU_DW+1)'(r1_req.b_imag)
                 : (CAU_DW+1)'(r1_req.a_imag) + (CAU_DW+1)'(r1_req.b_imag);
    end

    always_comb begin
        unique case (r2_op)
            OP_ADD, OP_SUB: begin
                n3_sum_re = CAU_SW'(r2_as_re);
                n3_sum_im = CAU_SW'(r2_as_im);
            end
            OP_MUL: begin
                n3_sum_re = CAU_SW'(r2_rr) - CAU_SW'(r2_ii);
                n3_sum_im = CAU_SW'(r2_ri) + CAU_SW'(r2_ir);
            end
            OP_DIV: begin
                n3_sum_re = CAU_SW'(r2_rr) + CAU_SW'(r2_ii);
                n3_sum_im = CAU_SW'(r2_ir) - CAU_SW'(r2_ri);
            end
            default: begin
                n3_sum_re = '0;
                n3_sum_im = '0;
            end
        endcase
    end

    always_comb begin
        n4_stage.op      = r3_op;
        n4_stage.sum_re  = r3_sum_re;
        n4_stage.sum_im  = r3_sum_im;
        n4_stage.den     = r3_den;
        n4_stage.dz      = (r3_op == OP_DIV) && (r3_den == '0);
        n4_stage.lane_re = prep_lane(r3_sum_re, r3_den);
        n4_stage.lane_im = prep_lane(r3_sum_im, r3_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (!s1) r1_v <= i_valid;
            if (!s2) r2_v <= r1_v;
            if (!s3) r3_v <= r2_v;
            if (!s4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1) r1_req <= i_req;
        if (!s2) begin
            r2_op    <= r1_req.req_type;
            r2_rr    <= n2_rr;
            r2_ii    <= n2_ii;
            r2_ri    <= n2_ri;
            r2_ir    <= n2_ir;
            r2_bb    <= n2_bb;
            r2_cc    <= n2_cc;
            r2_as_re <= n2_as_re;
            r2_as_im <= n2_as_im;
        end
        if (!s3) begin
            r3_op     <= r2_op;
            r3_sum_re <= n3_sum_re;
            r3_sum_im <= n3_sum_im;
            r3_den    <= r2_bb + r2_cc;
        end
        if (!s4) r4_stage <= n4_stage;
    end

endmodule

/* rtl/core/cau_div_step.sv */
`timescale 1ns / 1ps
module cau_div_step import cau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_stall,
    output logic   o_valid,
    output t_stage o_stage,
    input  logic   i_stall
);

    logic   r_v;
    t_stage r_stage;
    t_stage n_stage;

    // shift in one dividend bit, subtract the divisor if it fits
    function automatic t_lane step_lane(input t_lane l, input logic [CAU_PW-1:0] den);
        t_lane             o;
        logic [CAU_RW-1:0] sh;
        logic              fit;
        sh     = {l.rem[CAU_RW-2:0], l.bits[CAU_QB-1]};
        fit    = sh >= CAU_RW'(den);
        o      = l;
        o.rem  = fit ? sh - CAU_RW'(den) : sh;
        o.bits = {l.bits[CAU_QB-2:0], fit};
        return o;
    endfunction

    always_comb begin
        n_stage         = i_stage;
        n_stage.lane_re = step_lane(i_stage.lane_re, i_stage.den);
        n_stage.lane_im = step_lane(i_stage.lane_im, i_stage.den);
    end

    assign o_stall = r_v && i_stall;
    assign o_valid = r_v;
    assign o_stage = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) r_stage <= n_stage;
    end

endmodule

/* rtl/core/cau_back.sv */
`timescale 1ns / 1ps
module cau_back import cau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_stage i_stage,
    output logic   o_stall,
    output logic   o_valid,
    output t_res   o_res,
    input  logic   i_stall
);

    logic                     r_v;
    t_res                     r_res;
    t_res                     n_res;
    logic signed [CAU_SW-1:0] n_re, n_im;

    function automatic logic signed [CAU_SW-1:0] div_val(input t_lane l);
        logic [CAU_QB:0] q;
        q = ({1'b0, l.bits} + (CAU_QB+1)'(1)) >> 1;
        if (l.ovf) return l.neg ? CAU_MINV - CAU_SW'(1) : CAU_MAXV + CAU_SW'(1);
        return l.neg ? -CAU_SW'(q) : CAU_SW'(q);
    endfunction

    always_comb begin
        unique case (i_stage.op)
            OP_ADD, OP_SUB: begin
                n_re = i_stage.sum_re;
                n_im = i_stage.sum_im;
            end
            OP_MUL: begin
                n_re = (i_stage.sum_re + CAU_HALF) >>> CAU_FB;
                n_im = (i_stage.sum_im + CAU_HALF) >>> CAU_FB;
            end
            OP_DIV: begin
                n_re = i_stage.dz ? '0 : div_val(i_stage.lane_re);
                n_im = i_stage.dz ? '0 : div_val(i_stage.lane_im);
            end
            default: begin
                n_re = '0;
                n_im = '0;
            end
        endcase
        // clamp to the output range
        n_res.res_real = (n_re > CAU_MAXV) ? CAU_DW'(CAU_MAXV)
                       : (n_re < CAU_MINV) ? CAU_DW'(CAU_MINV) : CAU_DW'(n_re);
        n_res.res_imag = (n_im > CAU_MAXV) ? CAU_DW'(CAU_MAXV)
                       : (n_im < CAU_MINV) ? CAU_DW'(CAU_MINV) : CAU_DW'(n_im);
        n_res.overflow = (n_re > CAU_MAXV) || (n_re < CAU_MINV)
                      || (n_im > CAU_MAXV) || (n_im < CAU_MINV);
        n_res.div_by_zero = i_stage.dz;
    end

    assign o_stall = r_v && i_stall;
    assign o_valid = r_v;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) r_res <= n_res;
    end

endmodule

/* rtl/core/complex_arith_unit.sv */
`timescale 1ns / 1ps
// Complex ALU on Q4.12 operands: add, subtract, multiply (rounded half up)
// and divide (conj(B)*A over |B|^2, rounded half away from zero). Each beat
// carries one operation and returns one result beat; parts outside the
// 16-bit range saturate and raise overflow, and a divide by a zero divisor
// returns zero with div_by_zero set. The unit takes a new beat every cycle
// while o_stall is low. Every operation passes four front stages (operand
// register, six 16x16 multipliers, the sums and divisor magnitude, divide
// setup), seventeen restoring divider stages that each retire one quotient
// bit for the real and imaginary parts together, and the output register.
// All operations run the same path, so results leave in order. Each stage
// holds its own valid bit and fills bubbles while the output is stalled, so
// o_stall rises only when every stage holds a beat.
module complex_arith_unit import cau_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_valid,
    output t_res o_res,
    input  logic i_stall
);

    // chain between the front stages, divider stages and output register
    logic   div_v     [CAU_QB+1];
    logic   div_stall [CAU_QB+1];
    t_stage div_stage [CAU_QB+1];

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .o_valid (div_v[0]),
        .o_stage (div_stage[0]),
        .i_stall (div_stall[0])
    );

    // one quotient bit per stage
    for (genvar g = 0; g < CAU_QB; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_v[g]),
            .i_stage (div_stage[g]),
            .o_stall (div_stall[g]),
            .o_valid (div_v[g+1]),
            .o_stage (div_stage[g+1]),
            .i_stall (div_stall[g+1])
        );
    end

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_v[CAU_QB]),
        .i_stage (div_stage[CAU_QB]),
        .o_stall (div_stall[CAU_QB]),
        .o_valid (o_valid),
        .o_res   (o_res),
        .i_stall (i_stall)
    );

    // a zero divisor gives a clean zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.div_by_zero |->
            o_res.res_real == '0 && o_res.res_imag == '0 && !o_res.overflow)
        else $error("div_by_zero beat with nonzero result");

    // overflow only with a part pinned at a rail
    a_ovf_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.overflow |->
            o_res.res_real == CAU_DW'(CAU_MAXV) || o_res.res_real == CAU_DW'(CAU_MINV) ||
            o_res.res_imag == CAU_DW'(CAU_MAXV) || o_res.res_imag == CAU_DW'(CAU_MINV))
        else $error("overflow flag without saturated part");

    // back pressure reaches the input only through a full, stalled output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && div_v[0])
        else $error("input stalled while pipeline can advance");

endmodule

/* verif/complex_arith_unit_tb.sv */
`timescale 1ns / 1ps
module complex_arith_unit_tb;
    import cau_pkg::*;

    localparam int N_RANDOM   = 1250;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 120;

    // num * 2^FB / den, rounded half away from zero
    function automatic longint quot_round(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< (CAU_FB + 1)) / den + 1) >>> 1;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [CAU_DW-1:0] sat16(longint x, inout bit ovf);
        longint hi, lo;
        hi = (64'sd1 <<< (CAU_DW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            ovf = 1;
            x = hi;
        end
        if (x < lo) begin
            ovf = 1;
            x = lo;
        end
        return x[CAU_DW-1:0];
    endfunction

    // Predict one result beat at Q4.12: exact sums, rounded products,
    // long division for the quotient.
    function automatic t_res cplx_predict(t_req r);
        t_res   o;
        longint ar, ai, br, bi, re, im, den;
        bit     ovf;
        ar = longint'(r.a_real);
        ai = longint'(r.a_imag);
        br = longint'(r.b_real);
        bi = longint'(r.b_imag);
        re = 0;
        im = 0;
        ovf = 0;
        o = '0;
        case (r.req_type)
            OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL: begin
                // add half an LSB, then floor: ties go up
                re = (ar * br - ai * bi + (64'sd1 <<< (CAU_FB - 1))) >>> CAU_FB;
                im = (ar * bi + ai * br + (64'sd1 <<< (CAU_FB - 1))) >>> CAU_FB;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    o.div_by_zero = 1'b1;
                end else begin
                    re = quot_round(ar * br + ai * bi, den);
                    im = quot_round(ai * br - ar * bi, den);
                end
            end
        endcase
        o.res_real = sat16(re, ovf);
        o.res_imag = sat16(im, ovf);
        o.overflow = ovf;
        return o;
    endfunction

    class cplx_scoreboard;
        t_res pending[$];
        int   n_bad;

        function void note_req(t_req r);
            pending.push_back(cplx_predict(r));
        endfunction

        function void check_res(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.res_real !== want.res_real || got.res_imag !== want.res_imag ||
                got.overflow !== want.overflow || got.div_by_zero !== want.div_by_zero) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: exp re=%0d im=%0d ovf=%b dz=%b, ",
                             want.res_real, want.res_imag, want.overflow, want.div_by_zero,
                             "got re=%0d im=%0d ovf=%b dz=%b",
                             got.res_real, got.res_imag, got.overflow, got.div_by_zero);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_stall, o_stall, o_valid;
    t_req i_req;
    t_res o_res;

    cplx_scoreboard sb;
    int  cycle_cnt = 0;
    bit  quiet_mode;    // no idling on either side
    bit  hold_now;      // receiver long hold-off

    complex_arith_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_req  (i_req),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_res  (o_res),
        .i_stall(i_stall)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Check every accepted result beat, and note accepted input beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            if (i_valid && !o_stall)
                sb.note_req(i_req);
            if (o_valid && !i_stall)
                sb.check_res(o_res);
        end
    end

    // Receiver stall: random, or held high for a long stretch on request.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else if (hold_now)
            i_stall <= 1'b1;
        else
            i_stall <= !quiet_mode && ($urandom_range(99) < 9);
    end

    // Run-time limit.
    always @(posedge i_clk) begin
        if (cycle_cnt > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [CAU_DW-1:0] rand_part();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return CAU_DW'($urandom_range(8191)) - 16'sd4096;   // near +-1.0
            4: return CAU_DW'($urandom_range(255)) - 16'sd128;     // tiny divisors
            default: return CAU_DW'($urandom());
        endcase
    endfunction

    // Offer one beat; hold it until accepted. Optionally idle first.
    task automatic send_beat(t_req r, bit may_idle);
        while (may_idle && !quiet_mode && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic send_one(t_op op, int ar, int ai, int br, int bi);
        t_req r;
        r.req_type = op;
        r.a_real   = ar[CAU_DW-1:0];
        r.a_imag   = ai[CAU_DW-1:0];
        r.b_real   = br[CAU_DW-1:0];
        r.b_imag   = bi[CAU_DW-1:0];
        send_beat(r, 1'b1);
    endtask

    // Let the monitor note the last accepted beat, then wait for every result.
    task automatic drain_wait();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus.
    initial begin
        t_req r;
        sb = new();
        quiet_mode = 0;
        hold_now   = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, zero divisor, rounding ties.
        send_one(OP_ADD, 32767, 32767, 1, 1);
        send_one(OP_ADD, -32768, -32768, -1, -1);
        send_one(OP_SUB, -32768, 32767, 1, -1);
        send_one(OP_SUB, 32767, -32768, 32767, -32768);
        send_one(OP_MUL, -32768, -32768, -32768, -32768);
        send_one(OP_MUL, -32768, 0, -32768, 0);
        send_one(OP_MUL, 32767, 32767, 32767, -32768);
        send_one(OP_MUL, 4096, 0, 1, 0);
        send_one(OP_MUL, 2048, 0, 1, 0);       // exact tie, positive
        send_one(OP_MUL, -2048, 0, 1, 0);      // exact tie, negative
        send_one(OP_MUL, 4096, 4096, 4096, -4096);
        send_one(OP_DIV, 1234, -5678, 0, 0);   // zero divisor
        send_one(OP_DIV, -32768, -32768, 0, 0);
        send_one(OP_DIV, 4096, 0, 4096, 0);
        send_one(OP_DIV, -32768, -32768, 1, 0);
        send_one(OP_DIV, 32767, 32767, -32768, -32768);
        send_one(OP_DIV, 1, 0, 2, 0);
        send_one(OP_DIV, -1, 0, 8192, 0);      // tie away from zero
        send_one(OP_DIV, 3, 7, -1, 1);
        send_one(OP_DIV, 0, 0, 32767, -32768);
        send_one(OP_ADD, 0, 0, 0, 0);

        // Random beats, with a quiet stretch, a long receiver hold-off
        // and a full drain pause along the way.
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 300) quiet_mode = 1;
            if (k == 500) quiet_mode = 0;
            if (k == 700) begin
                fork
                    begin
                        hold_now = 1;
                        repeat (HOLD_LEN) @(posedge i_clk);
                        hold_now = 0;
                    end
                join_none
            end
            if (k == 900)
                drain_wait();
            r.req_type = t_op'($urandom_range(3));
            r.a_real   = rand_part();
            r.a_imag   = rand_part();
            r.b_real   = rand_part();
            r.b_imag   = rand_part();
            if ($urandom_range(19) == 0) begin
                r.b_real = '0;
                r.b_imag = '0;
            end
            send_beat(r, 1'b1);
        end
        drain_wait();
        repeat (40) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_div_step.sv
rtl/core/cau_back.sv
rtl/core/complex_arith_unit.sv
verif/complex_arith_unit_tb.sv
